// ===== hdl/ffbp_pkg.sv =====
package ffbp_pkg;

    localparam int CAP_W = 16;
    localparam int ITEM_W = 16;
    localparam int OUT_IDX_W = 6;
    localparam int OUT_CNT_W = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int NUM_BINS_DEF = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_PLACE = 1'b1;

    localparam logic REG_BIN_CAPACITY = 1'b0;

    typedef struct packed {
        logic valid;
        logic cmd;
        logic placed;
        logic fresh;
    } tok_t;

endpackage

// ===== hdl/ffbp_cell.sv =====
module ffbp_cell #(
    parameter int IDX_W = 6,
    parameter int WEIGHT_W = 16,
    parameter int CELL_INDEX = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic [ffbp_pkg::CAP_W-1:0] bin_capacity,
    input  ffbp_pkg::tok_t             tok_in,
    input  logic [WEIGHT_W-1:0]        weight_in,
    input  logic [IDX_W-1:0]           idx_in,
    output ffbp_pkg::tok_t             tok_out,
    output logic [WEIGHT_W-1:0]        weight_out,
    output logic [IDX_W-1:0]           idx_out
);

    localparam int SUM_W = ffbp_pkg::CAP_W + 1;

    logic [ffbp_pkg::CAP_W-1:0] fill_reg, fill_next;
    ffbp_pkg::tok_t             tok_reg, tok_next;
    logic [WEIGHT_W-1:0]        weight_reg;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [SUM_W-1:0]           sum;
    logic                       fits;

    assign sum  = {1'b0, fill_reg} + {{(SUM_W-WEIGHT_W){1'b0}}, weight_in};
    assign fits = (sum <= {1'b0, bin_capacity});

    always_comb begin
        fill_next = fill_reg;
        tok_next  = tok_in;
        idx_next  = idx_in;
        if (tok_in.valid) begin
            if (tok_in.cmd == ffbp_pkg::CMD_CLEAR) begin
                fill_next = '0;
            end else if (!tok_in.placed && fits) begin
                fill_next       = sum[ffbp_pkg::CAP_W-1:0];
                tok_next.placed = 1'b1;
                tok_next.fresh  = (fill_reg == '0) && (weight_in != '0);
                idx_next        = IDX_W'(CELL_INDEX);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            tok_reg  <= '0;
        end else if (advance) begin
            fill_reg <= fill_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            weight_reg <= weight_in;
            idx_reg    <= idx_next;
        end
    end

    assign tok_out    = tok_reg;
    assign weight_out = weight_reg;
    assign idx_out    = idx_reg;

endmodule

// ===== hdl/first_fit_bin_packer_core.sv =====
// First-fit bin packer. Every request (clear or place) travels down a chain of NUM_BINS
// cells, one cell per cycle unless the output stalls, and each cell owns one bin fill
// level; the first cell whose fill plus the weight stays within bin_capacity takes the
// item, and a clear zeroes each cell as it passes. The block accepts one request per
// cycle unless the output stalls; the first cell registers it at the accepting edge,
// each cell registers it in turn, then the output register. Results come out in
// request order. A stalled result holds the whole chain. bin_capacity is written
// at APB address 0 while no request is in flight; the user must ensure this, not the block.
module first_fit_bin_packer_core #(
    parameter int NUM_BINS = ffbp_pkg::NUM_BINS_DEF,
    parameter int WEIGHT_BITS = ffbp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffbp_pkg::PADDR_W-1:0]   paddr,
    input  logic [ffbp_pkg::PDATA_W-1:0]   pwdata,
    output logic [ffbp_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [ffbp_pkg::ITEM_W-1:0]    s_item_weight,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_placed,
    output logic [ffbp_pkg::OUT_IDX_W-1:0] m_bin_index,
    output logic [ffbp_pkg::OUT_CNT_W-1:0] m_bins_in_use
);

    localparam int IDX_W = $clog2(NUM_BINS);
    localparam int CNT_W = $clog2(NUM_BINS + 1);
    localparam int WEIGHT_W = (WEIGHT_BITS < ffbp_pkg::ITEM_W) ? WEIGHT_BITS : ffbp_pkg::ITEM_W;

    logic [ffbp_pkg::CAP_W-1:0] cap_reg;
    logic                       cap_wr;

    logic                       advance;
    ffbp_pkg::tok_t             tok_chain [NUM_BINS+1];
    logic [WEIGHT_W-1:0]        weight_chain [NUM_BINS+1];
    logic [IDX_W-1:0]           idx_chain [NUM_BINS+1];

    logic                       m_valid_reg;
    logic                       m_placed_reg;
    logic [ffbp_pkg::OUT_IDX_W-1:0] m_bin_index_reg;
    logic [ffbp_pkg::OUT_CNT_W-1:0] m_bins_in_use_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W+ffbp_pkg::OUT_IDX_W-1:0] idx_ext;
    logic [CNT_W+ffbp_pkg::OUT_CNT_W-1:0] cnt_ext;
    ffbp_pkg::tok_t             tok_last;

    assign pready = 1'b1;
    assign cap_wr = psel && penable && pwrite && (paddr[2] == ffbp_pkg::REG_BIN_CAPACITY);
    assign prdata = (paddr[2] == ffbp_pkg::REG_BIN_CAPACITY)
                  ? {{(ffbp_pkg::PDATA_W-ffbp_pkg::CAP_W){1'b0}}, cap_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= ffbp_pkg::CAP_RESET;
        end else if (cap_wr) begin
            cap_reg <= pwdata[ffbp_pkg::CAP_W-1:0];
        end
    end

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    always_comb begin
        tok_chain[0]        = '0;
        tok_chain[0].valid  = s_valid;
        tok_chain[0].cmd    = s_command;
        weight_chain[0]     = s_item_weight[WEIGHT_W-1:0];
        idx_chain[0]        = '0;
    end

    for (genvar b = 0; b < NUM_BINS; b++) begin : g_cell
        ffbp_cell #(
            .IDX_W      (IDX_W),
            .WEIGHT_W   (WEIGHT_W),
            .CELL_INDEX (b)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .advance      (advance),
            .bin_capacity (cap_reg),
            .tok_in       (tok_chain[b]),
            .weight_in    (weight_chain[b]),
            .idx_in       (idx_chain[b]),
            .tok_out      (tok_chain[b+1]),
            .weight_out   (weight_chain[b+1]),
            .idx_out      (idx_chain[b+1])
        );
    end

    assign tok_last = tok_chain[NUM_BINS];

    always_comb begin
        count_next = count_reg;
        if (tok_last.valid) begin
            if (tok_last.cmd == ffbp_pkg::CMD_CLEAR) begin
                count_next = '0;
            end else if (tok_last.fresh) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    assign idx_ext = {{ffbp_pkg::OUT_IDX_W{1'b0}}, idx_chain[NUM_BINS]};
    assign cnt_ext = {{ffbp_pkg::OUT_CNT_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else if (advance) begin
            m_valid_reg <= tok_last.valid;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_placed_reg      <= tok_last.placed;
            m_bin_index_reg   <= tok_last.placed ? idx_ext[ffbp_pkg::OUT_IDX_W-1:0] : '0;
            m_bins_in_use_reg <= cnt_ext[ffbp_pkg::OUT_CNT_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_placed      = m_placed_reg;
    assign m_bin_index   = m_bin_index_reg;
    assign m_bins_in_use = m_bins_in_use_reg;

endmodule
